/* rtl/breakpoint_curve_interpolator_defines.svh */
// Assertion macros for the breakpoint curve interpolator.
// No dependencies.
`ifndef BREAKPOINT_CURVE_INTERPOLATOR_DEFINES_SVH
`define BREAKPOINT_CURVE_INTERPOLATOR_DEFINES_SVH
`define BCI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BCI_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

/* rtl/bci_pkg.sv */
// Package for the breakpoint curve interpolator: sizes, opcodes, status codes, states.
// No dependencies.
package bci_pkg;
	localparam int MAX_POINTS = 16;
	localparam int FRAC_BITS  = 16;
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_MOVE   = 2'd2,
		OP_EVAL   = 2'd3
	} op_t;
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_INVAL = 2'd2
	} status_t;
	typedef enum logic [3:0] {
		S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT, S_REM_RD, S_REM_WR,
		S_MV_RD, S_MV_NB, S_MV_WR, S_EV_LAST, S_EV_CHK, S_EV_WALK,
		S_EV_MUL, S_EV_DIV, S_EV_FIN, S_DONE
	} state_t;
endpackage

/* rtl/bci_ram.sv */
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module bci_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* rtl/breakpoint_curve_interpolator.sv */
// Top level of the breakpoint curve interpolator.
// Depends on bci_pkg, bci_ram and breakpoint_curve_interpolator_defines.svh.
`include "breakpoint_curve_interpolator_defines.svh"
// One request at a time: a request is taken when start is high and busy is low,
// and busy stays high until the cycle after the result. The result is on level,
// status and point_count in the single cycle that done is high and holds until
// the next request is taken; the receiver cannot stall and must take it then.
// Insert shifts up each point whose x lies above the new x, then writes it.
// Remove shifts down the points above the index. Move reads the neighbors, then
// writes the clamped point. Evaluate answers at or beyond an end point directly,
// else walks to the segment that holds x, does one multiply and a 16-step divide.
// Refused, disabled or empty requests go to done directly; the next request can be taken in the cycle after done.
module breakpoint_curve_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [15:0] point_x,
	input  logic [15:0] point_y,
	input  logic [3:0]  point_index,
	input  logic [16:0] x_delta,
	input  logic [16:0] y_delta,
	input  logic [15:0] eval_x,
	output logic        done,
	output logic [16:0] level,
	output logic [1:0]  status,
	output logic [4:0]  point_count
);
	import bci_pkg::*;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int W  = FRAC_BITS;
	localparam int BW = $clog2(W);

	state_t state_q, state_nx;
	logic enabled_q;
	logic [CW-1:0] cnt_q, i_q;
	logic [W-1:0] px_q, py_q, ex_q;
	logic [AW-1:0] idx_q;
	logic [W:0] dx_q, dy_q;
	status_t st_q, st_new;
	logic [W:0] lvl_q;
	logic [W-1:0] ax_q, bx_q, by_q, cx_q;
	logic [W-1:0] prevx_q, prevy_q;
	logic [W-1:0] den_q, dxm_q, dym_q, ybase_q, rem_q, lo_q;
	logic neg_q;
	logic [BW-1:0] bit_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [2*W-1:0] wdata, rdata;
	logic [W-1:0] rx, ry;

	logic full, idx_bad, rem_more;
	logic signed [W+1:0] nx, ny;
	logic [W-1:0] mvx, mvy;
	logic [W:0] rem_sh, rem_sub;
	logic [2*W-1:0] prod;
	logic [W-1:0] y_fin;

	bci_ram #(.WIDTH(2 * W), .DEPTH(MAX_POINTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign rx = rdata[2*W-1:W];
	assign ry = rdata[W-1:0];

	assign full = (cnt_q >= CW'(MAX_POINTS));
	assign idx_bad = (CW'(point_index) >= cnt_q) || (point_index == '0) ||
		(CW'(point_index) == cnt_q - 1'b1);
	assign rem_more = ((CW+1)'(i_q) + (CW+1)'(2)) < (CW+1)'(cnt_q);

	always_comb begin
		case (op_t'(opcode)) inside
			OP_INSERT:         st_new = full ? ST_FULL : ST_OK;
			OP_REMOVE, OP_MOVE: st_new = idx_bad ? ST_INVAL : ST_OK;
			default:           st_new = ST_OK;
		endcase
	end

	// move: clamp x between the neighbors, y to the table range
	always_comb begin
		nx = $signed({2'b00, bx_q}) + $signed({dx_q[W], dx_q});
		ny = $signed({2'b00, by_q}) + $signed({dy_q[W], dy_q});
		if (nx < $signed({2'b00, ax_q})) mvx = ax_q;
		else if (nx > $signed({2'b00, cx_q})) mvx = cx_q;
		else mvx = nx[W-1:0];
		if (ny < 0) mvy = '0;
		else if (ny > $signed({2'b00, {W{1'b1}}})) mvy = {W{1'b1}};
		else mvy = ny[W-1:0];
	end

	assign rem_sh = {rem_q, lo_q[W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign prod = dxm_q * dym_q;
	assign y_fin = neg_q ? ybase_q - lo_q : ybase_q + lo_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (start) begin
				unique case (op_t'(opcode))
					OP_INSERT: state_nx = full ? S_DONE : S_INS_RD;
					OP_REMOVE: state_nx = idx_bad ? S_DONE : S_REM_RD;
					OP_MOVE:   state_nx = idx_bad ? S_DONE : S_MV_RD;
					OP_EVAL:   state_nx = (!enabled_q || cnt_q == '0) ? S_DONE : S_EV_LAST;
					default:   state_nx = S_DONE;
				endcase
			end
			S_INS_RD: state_nx = (i_q == '0) ? S_INS_PUT : S_INS_CMP;
			S_INS_CMP: state_nx = (rx > px_q) ? S_INS_RD : S_INS_PUT;
			S_INS_PUT: state_nx = S_DONE;
			S_REM_RD: state_nx = S_REM_WR;
			S_REM_WR: state_nx = rem_more ? S_REM_RD : S_DONE;
			S_MV_RD: state_nx = S_MV_NB;
			S_MV_NB: state_nx = (i_q == CW'(2)) ? S_MV_WR : S_MV_NB;
			S_MV_WR: state_nx = S_DONE;
			S_EV_LAST: state_nx = S_EV_CHK;
			S_EV_CHK: state_nx = (ex_q >= rx) ? S_EV_FIN : S_EV_WALK;
			S_EV_WALK: begin
				if (i_q == '0) state_nx = (ex_q <= rx) ? S_EV_FIN : S_EV_WALK;
				else state_nx = (rx >= ex_q) ? S_EV_MUL : S_EV_WALK;
			end
			S_EV_MUL: state_nx = S_EV_DIV;
			S_EV_DIV: state_nx = (bit_q == '0) ? S_EV_FIN : S_EV_DIV;
			S_EV_FIN: state_nx = S_DONE;
			S_DONE: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// memory address and control
	always_comb begin
		we = 1'b0;
		raddr = '0;
		waddr = i_q[AW-1:0];
		wdata = rdata;
		unique case (state_q)
			S_INS_RD: raddr = AW'(i_q - 1'b1);
			S_INS_CMP: we = (rx > px_q);
			S_INS_PUT: begin
				we = 1'b1;
				wdata = {px_q, py_q};
			end
			S_REM_RD: raddr = AW'(i_q + 1'b1);
			S_REM_WR: we = 1'b1;
			S_MV_RD: raddr = idx_q - 1'b1;
			S_MV_NB: raddr = idx_q + i_q[AW-1:0];
			S_MV_WR: begin
				we = 1'b1;
				waddr = idx_q;
				wdata = {mvx, mvy};
			end
			S_EV_LAST: raddr = AW'(cnt_q - 1'b1);
			S_EV_CHK: raddr = '0;
			S_EV_WALK: raddr = AW'(i_q + 1'b1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			enabled_q <= 1'b1;
			cnt_q <= '0;
			i_q <= '0;
			st_q <= ST_OK;
			lvl_q <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) enabled_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: if (start) begin
					i_q <= (op_t'(opcode) == OP_REMOVE) ? CW'(point_index) : cnt_q;
					st_q <= st_new;
					lvl_q <= '0;
				end
				S_INS_CMP: if (rx > px_q) i_q <= i_q - 1'b1;
				S_INS_PUT: cnt_q <= cnt_q + 1'b1;
				S_REM_WR: begin
					i_q <= i_q + 1'b1;
					if (!rem_more) cnt_q <= cnt_q - 1'b1;
				end
				S_MV_RD: i_q <= '0;
				S_MV_NB: i_q <= i_q + 1'b1;
				S_EV_CHK: i_q <= '0;
				S_EV_WALK: i_q <= i_q + 1'b1;
				S_EV_FIN: lvl_q <= {1'b1, {W{1'b0}}} - {1'b0, y_fin};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) begin
				px_q <= point_x;
				py_q <= point_y;
				ex_q <= eval_x;
				idx_q <= point_index;
				dx_q <= x_delta;
				dy_q <= y_delta;
			end
			S_MV_NB: begin
				if (i_q == '0) ax_q <= rx;
				if (i_q == CW'(1)) begin
					bx_q <= rx;
					by_q <= ry;
				end
				if (i_q == CW'(2)) cx_q <= rx;
			end
			S_EV_CHK: begin
				ybase_q <= ry;
				lo_q <= '0;
				neg_q <= 1'b0;
			end
			// segment found when x of the current entry reaches ex
			S_EV_WALK: begin
				prevx_q <= rx;
				prevy_q <= ry;
				ybase_q <= (i_q == '0) ? ry : prevy_q;
				den_q <= rx - prevx_q;
				dxm_q <= ex_q - prevx_q;
				neg_q <= (i_q != '0) && (ry < prevy_q);
				dym_q <= (ry < prevy_q) ? prevy_q - ry : ry - prevy_q;
				lo_q <= '0;
			end
			// high half of the product is below den, so W steps suffice
			S_EV_MUL: begin
				rem_q <= prod[2*W-1:W];
				lo_q <= prod[W-1:0];
				bit_q <= BW'(W - 1);
			end
			S_EV_DIV: begin
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sub[W-1:0];
					lo_q <= {lo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[W-1:0];
					lo_q <= {lo_q[W-2:0], 1'b0};
				end
				bit_q <= bit_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign level = lvl_q;
	assign status = st_q;
	assign point_count = 5'(cnt_q);

	`BCI_ASSERT(a_cnt_max, clk, arst_n, cnt_q <= CW'(MAX_POINTS), "count over capacity")
	`BCI_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy, "done not followed by idle")
	`BCI_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "request not taken")
endmodule

/* verif/tb_breakpoint_curve_interpolator.sv */
// Self-checking testbench for breakpoint_curve_interpolator: directed and random requests
// against an in-bench breakpoint table predictor. Depends on bci_pkg and the block's RTL.
module tb_breakpoint_curve_interpolator;
	import bci_pkg::*;

	localparam int NPTS = MAX_POINTS;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [16:0] level;
		status_t     status;
		logic [4:0]  point_count;
	} curve_result_t;

	logic clk, arst_n, cfg_we, cfg_wdata, start, busy, done;
	op_t opcode;
	logic [15:0] point_x, point_y, eval_x;
	logic [3:0] point_index;
	logic [16:0] x_delta, y_delta, level;
	logic [1:0] status;
	logic [4:0] point_count;

	logic [15:0] tbl_x [NPTS];
	logic [15:0] tbl_y [NPTS];
	int n_pts;
	logic curve_on;
	curve_result_t pending_q[$];
	int errors, n_results, cycles, n_req;
	int gap_left, burst_left;

	breakpoint_curve_interpolator u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .opcode(opcode), .point_x(point_x),
		.point_y(point_y), .point_index(point_index), .x_delta(x_delta),
		.y_delta(y_delta), .eval_x(eval_x), .done(done), .level(level),
		.status(status), .point_count(point_count)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	function automatic logic [15:0] curve_y(logic [15:0] x);
		longint x1, x2, y1, y2, q;
		if (x >= tbl_x[n_pts-1]) return tbl_y[n_pts-1];
		if (x <= tbl_x[0]) return tbl_y[0];
		for (int i = 0; i + 1 < n_pts; i++) begin
			x1 = tbl_x[i]; x2 = tbl_x[i+1]; y1 = tbl_y[i]; y2 = tbl_y[i+1];
			if (x >= x1 && x <= x2) begin
				if (x1 == x2) return 16'(y1);
				if (y2 >= y1) begin
					q = ((x - x1) * (y2 - y1)) / (x2 - x1);
					return 16'(y1 + q);
				end
				q = ((x - x1) * (y1 - y2)) / (x2 - x1);
				return 16'(y1 - q);
			end
		end
		return '0;
	endfunction

	function automatic curve_result_t apply_request(op_t op, logic [15:0] px, logic [15:0] py,
			logic [3:0] idx, logic [16:0] dx, logic [16:0] dy, logic [15:0] ex);
		curve_result_t r;
		int pos;
		longint nx, ny;
		r.level = '0;
		r.status = ST_OK;
		case (op)
			OP_INSERT: begin
				if (n_pts >= NPTS) r.status = ST_FULL;
				else begin
					pos = n_pts;
					for (int i = n_pts - 1; i >= 0; i--) if (tbl_x[i] > px) pos = i;
					for (int i = n_pts; i > pos; i--) begin
						tbl_x[i] = tbl_x[i-1]; tbl_y[i] = tbl_y[i-1];
					end
					tbl_x[pos] = px; tbl_y[pos] = py;
					n_pts++;
				end
			end
			OP_REMOVE, OP_MOVE: begin
				if (idx >= n_pts || idx == 0 || idx == n_pts - 1) r.status = ST_INVAL;
				else if (op == OP_REMOVE) begin
					for (int i = idx; i + 1 < n_pts; i++) begin
						tbl_x[i] = tbl_x[i+1]; tbl_y[i] = tbl_y[i+1];
					end
					n_pts--;
				end else begin
					nx = longint'(tbl_x[idx]) + longint'($signed(dx));
					ny = longint'(tbl_y[idx]) + longint'($signed(dy));
					if (nx < longint'(tbl_x[idx-1])) nx = longint'(tbl_x[idx-1]);
					if (nx > longint'(tbl_x[idx+1])) nx = longint'(tbl_x[idx+1]);
					if (ny < 0) ny = 0;
					if (ny > 65535) ny = 65535;
					tbl_x[idx] = nx[15:0]; tbl_y[idx] = ny[15:0];
				end
			end
			default: if (curve_on && n_pts > 0) r.level = 17'h10000 - curve_y(ex);
		endcase
		r.point_count = n_pts[4:0];
		return r;
	endfunction

	// result checker: done is a one-cycle strobe
	always @(posedge clk) begin
		curve_result_t exp_r;
		if (arst_n && done) begin
			n_results++;
			if (pending_q.size() == 0) begin
				$display("%0t unexpected result level=%0d status=%0d count=%0d",
					$time, level, status, point_count);
				errors++;
			end else begin
				exp_r = pending_q.pop_front();
				if (level !== exp_r.level) begin
					$display("%0t level exp %0d got %0d", $time, exp_r.level, level);
					errors++;
				end
				if (status !== exp_r.status) begin
					$display("%0t status exp %0d got %0d", $time, exp_r.status, status);
					errors++;
				end
				if (point_count !== exp_r.point_count) begin
					$display("%0t point_count exp %0d got %0d", $time,
						exp_r.point_count, point_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic drain();
		while (pending_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_enable(logic v);
		drain();
		cfg_we = 1'b1; cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		curve_on = v;
	endtask

	// sends one request from the falling edge; the sender sends in bursts with idle gaps
	task automatic send_request(op_t op, logic [15:0] px, logic [15:0] py, logic [3:0] idx,
			logic [16:0] dx, logic [16:0] dy, logic [15:0] ex);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 20);
		end
		repeat (gap_left) @(negedge clk);
		gap_left = 0;
		burst_left--;
		opcode = op; point_x = px; point_y = py; point_index = idx;
		x_delta = dx; y_delta = dy; eval_x = ex; start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_q.insert(pending_q.size(), apply_request(op, px, py, idx, dx, dy, ex));
		n_req++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic send_eval(logic [15:0] ex);
		send_request(OP_EVAL, 16'($urandom), 16'($urandom), 4'($urandom), 17'($urandom),
			17'($urandom), ex);
	endtask

	task automatic test_directed();
		send_eval(16'h1234);
		send_request(OP_REMOVE, '0, '0, 4'd0, '0, '0, '0);
		send_request(OP_MOVE, '0, '0, 4'd15, '0, '0, '0);
		send_request(OP_INSERT, 16'h0000, 16'hffff, '0, '0, '0, '0);
		send_eval(16'h0000);
		send_request(OP_INSERT, 16'hffff, 16'h0000, '0, '0, '0, '0);
		send_request(OP_INSERT, 16'h8000, 16'h4000, '0, '0, '0, '0);
		send_request(OP_INSERT, 16'h8000, 16'hc000, '0, '0, '0, '0);
		send_eval(16'h8000);
		send_eval(16'h4000);
		send_eval(16'hffff);
		send_eval(16'hc001);
		send_request(OP_MOVE, '0, '0, 4'd1, 17'h10000, 17'h10000, '0);
		send_request(OP_MOVE, '0, '0, 4'd2, 17'h0ffff, 17'h0ffff, '0);
		send_request(OP_MOVE, '0, '0, 4'd3, 17'h1, 17'h1, '0);
		send_request(OP_REMOVE, '0, '0, 4'd3, '0, '0, '0);
		send_request(OP_REMOVE, '0, '0, 4'd9, '0, '0, '0);
		send_request(OP_REMOVE, '0, '0, 4'd1, '0, '0, '0);
		send_eval(16'h7fff);
		for (int i = 0; i < 14; i++)
			send_request(OP_INSERT, 16'($urandom), 16'($urandom), '0, '0, '0, '0);
		send_request(OP_INSERT, 16'h5555, 16'haaaa, '0, '0, '0, '0);
		send_eval(16'h5555);
	endtask

	task automatic test_disabled();
		write_enable(1'b0);
		send_eval(16'h0000);
		send_eval(16'h9999);
		write_enable(1'b1);
	endtask

	// mostly valid inner-index requests on a populated table, plus noise
	task automatic test_random(int count);
		op_t op;
		logic [3:0] idx;
		logic [15:0] px;
		for (int k = 0; k < count; k++) begin
			if (k == count / 2) drain();
			if (k == count / 3) write_enable(1'b0);
			if (k == count / 3 + 40) write_enable(1'b1);
			op = op_t'($urandom_range(0, 3));
			if (n_pts < 4 && $urandom_range(0, 3) != 0) op = OP_INSERT;
			if (n_pts == NPTS && $urandom_range(0, 1) == 0) op = OP_REMOVE;
			idx = (n_pts > 2 && $urandom_range(0, 4) != 0) ?
				4'($urandom_range(1, n_pts - 2)) : 4'($urandom);
			px = ($urandom_range(0, 5) == 0 && n_pts > 0) ?
				tbl_x[$urandom_range(0, n_pts - 1)] : 16'($urandom);
			send_request(op, px, 16'($urandom), idx,
				($urandom_range(0, 1) ? 17'($urandom) : 17'($signed($urandom_range(0, 2000)) - 1000)),
				17'($urandom), ($urandom_range(0, 7) == 0) ? px : 16'($urandom));
		end
	endtask

	initial begin
		errors = 0; n_results = 0; cycles = 0; n_req = 0;
		gap_left = 0; burst_left = 0; n_pts = 0; curve_on = 1'b1;
		for (int i = 0; i < NPTS; i++) begin
			tbl_x[i] = '0; tbl_y[i] = '0;
		end
		arst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = 1'b1; start = 1'b0;
		opcode = OP_INSERT; point_x = '0; point_y = '0; point_index = '0;
		x_delta = '0; y_delta = '0; eval_x = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_disabled();
		test_random(1400);
		drain();
		$display("Covered %0d requests and %0d results: insert, remove, move, evaluate,",
			n_req, n_results);
		$display("full table, refused indexes, clamps, equal x, and the enable switch.");
		if (errors == 0 && pending_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
